>>> rtl/core/hsi_pkg.sv
// Shared constants and corner helpers for the hex spiral index converter.
package hsi_pkg;

    localparam int unsigned SIDES = 6;
    localparam int unsigned SIDE_BITS = 3;
    localparam int unsigned COORD_BITS = 18;
    localparam int unsigned IN_BITS = 32;

    typedef logic [SIDE_BITS-1:0] side_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [2:0] coef_t;

    function automatic coef_t corner_x(input side_t s);
        coef_t c;
        case (s)
            3'd0:    c = 3'sd2;
            3'd1:    c = 3'sd1;
            3'd2:    c = -3'sd1;
            3'd3:    c = -3'sd2;
            3'd4:    c = -3'sd1;
            3'd5:    c = 3'sd1;
            default: c = 3'sd0;
        endcase
        return c;
    endfunction

    function automatic coef_t corner_y(input side_t s);
        coef_t c;
        case (s)
            3'd1, 3'd2: c = 3'sd2;
            3'd4, 3'd5: c = -3'sd2;
            default:    c = 3'sd0;
        endcase
        return c;
    endfunction

    function automatic side_t next_side(input side_t s);
        side_t r;
        r = (s == side_t'(SIDES - 1)) ? side_t'(0) : side_t'(s + side_t'(1));
        return r;
    endfunction

    // Product of a value and a coefficient in -2..2, wrapped to the coordinate width.
    function automatic coord_t scale(input coord_t v, input coef_t c);
        coord_t r;
        case (c)
            3'sd1:   r = v;
            3'sd2:   r = coord_t'(v <<< 1);
            -3'sd1:  r = -v;
            -3'sd2:  r = -coord_t'(v <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/hsi_index_if.sv
// Handshake channel that carries one spiral cell index.
interface hsi_index_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_index;

    modport source (output valid, output cell_index, input ready);
    modport sink (input valid, input cell_index, output ready);
endinterface

>>> rtl/core/hsi_coord_if.sv
// Handshake channel that carries one pair of hex coordinates.
interface hsi_coord_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] x_coord;
    logic signed [17:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

>>> rtl/core/hsi_ring_cell.sv
// One cell of the ring search: decides one bit of the last complete ring.
module hsi_ring_cell #(
    parameter int unsigned IB  = 32,
    parameter int unsigned LB  = 17,
    parameter int unsigned BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [IB-1:0] in_n,
    input  logic [LB-1:0] in_lo,
    input  logic [IB-1:0] in_c,
    output logic          out_valid,
    output logic [IB-1:0] out_n,
    output logic [LB-1:0] out_lo,
    output logic [IB-1:0] out_c
);
    localparam int unsigned PW = 2 * LB + 1;
    localparam int unsigned CW = PW + 3;

    logic          valid_reg;
    logic [IB-1:0] n_reg;
    logic [LB-1:0] lo_reg, lo_next;
    logic [IB-1:0] c_reg, c_next;
    logic [LB-1:0] trial;
    logic [PW-1:0] prod;
    logic [CW-1:0] cells;
    logic          take;

    always_comb
    begin
        trial = in_lo | (LB'(1) << BIT);
        prod  = PW'(trial) * PW'({1'b0, trial} + (LB+1)'(1));
        cells = (CW'(prod) << 1) + CW'(prod) + CW'(1);
        if (CW > IB)
        begin
            take = cells <= CW'(in_n);
        end
        else
        begin
            take = IB'(cells) <= in_n;
        end
        lo_next = take ? trial : in_lo;
        c_next  = take ? IB'(cells) : in_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= in_n;
            lo_reg <= lo_next;
            c_reg  <= c_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_lo    = lo_reg;
    assign out_c     = c_reg;
endmodule

>>> rtl/core/hsi_side_cell.sv
// One cell of the side search: removes one side length from the ring offset when the offset holds one.
module hsi_side_cell #(
    parameter int unsigned IB = 32,
    parameter int unsigned LB = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_zero,
    input  logic [IB-1:0]         in_rem,
    input  logic [LB-1:0]         in_layer,
    input  hsi_pkg::side_t        in_side,
    output logic                  out_valid,
    output logic                  out_zero,
    output logic [IB-1:0]         out_rem,
    output logic [LB-1:0]         out_layer,
    output hsi_pkg::side_t        out_side
);
    import hsi_pkg::*;

    localparam int unsigned W = (IB > LB) ? IB : LB;

    logic          valid_reg;
    logic          zero_reg;
    logic [IB-1:0] rem_reg, rem_next;
    logic [LB-1:0] layer_reg;
    side_t         side_reg, side_next;
    logic          ge;

    always_comb
    begin
        ge = W'(in_rem) >= W'(in_layer);
        rem_next  = ge ? IB'(W'(in_rem) - W'(in_layer)) : in_rem;
        side_next = ge ? side_t'(in_side + side_t'(1)) : in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg  <= in_zero;
            rem_reg   <= rem_next;
            layer_reg <= in_layer;
            side_reg  <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_zero  = zero_reg;
    assign out_rem   = rem_reg;
    assign out_layer = layer_reg;
    assign out_side  = side_reg;
endmodule

>>> rtl/core/hex_spiral_index_to_coords.sv
// Top level of the hex spiral index to coordinate converter.
//
// An index arrives on index_ch and its doubled-x coordinates leave on
// coord_ch; both channels use a valid/ready transfer. Only the low
// INDEX_BITS bits of the index are used.
// The ring is found by a row of INDEX_BITS/2+1 search cells, one ring bit
// per cell, each holding one multiply and compare. Five side cells then
// strip whole sides from the ring offset, and an output stage forms the
// coordinates from the corner tables.
// One index is taken every cycle unless the receiver stalls the row, and
// there is no carried state between indexes.
// Each stage moves forward whenever the stage after it is empty or moving,
// so bubbles close up and new indexes are taken while a result waits.
// When the receiver stalls, the row fills and then index_ch.ready drops.
// Reset empties every stage; no results are pending after it.
module hex_spiral_index_to_coords #(
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hsi_index_if.sink   index_ch,
    hsi_coord_if.source coord_ch
);
    import hsi_pkg::*;

    localparam int unsigned IB = INDEX_BITS;
    localparam int unsigned LB = INDEX_BITS / 2 + 1;
    localparam int unsigned NSIDE = SIDES - 1;
    localparam int unsigned NST = LB + NSIDE + 1;

    logic          en [NST];
    logic          v  [NST];

    logic          rv  [LB+1];
    logic [IB-1:0] rn  [LB+1];
    logic [LB-1:0] rlo [LB+1];
    logic [IB-1:0] rc  [LB+1];

    logic          sv  [NSIDE+1];
    logic          sz  [NSIDE+1];
    logic [IB-1:0] sr  [NSIDE+1];
    logic [LB-1:0] sl  [NSIDE+1];
    side_t         ss  [NSIDE+1];

    logic          out_valid_reg;
    coord_t        x_reg, x_next;
    coord_t        y_reg, y_next;
    coord_t        layer_c, step_c;
    side_t         nside;

    // Ready ripples back from the output: a stage may load when it is empty
    // or when its content moves on in the same cycle.
    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (i < LB)
            begin
                v[i] = rv[i+1];
            end
            else if (i < LB + NSIDE)
            begin
                v[i] = sv[i-LB+1];
            end
            else
            begin
                v[i] = out_valid_reg;
            end
        end
        en[NST-1] = !v[NST-1] || coord_ch.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v[i] || en[i+1];
        end
    end

    assign rv[0]  = index_ch.valid;
    assign rn[0]  = IB'(index_ch.cell_index);
    assign rlo[0] = '0;
    assign rc[0]  = IB'(1);
    assign index_ch.ready = en[0];

    for (genvar g = 0; g < LB; g++)
    begin : g_ring
        hsi_ring_cell #(
            .IB  (IB),
            .LB  (LB),
            .BIT (LB - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[g]),
            .in_valid  (rv[g]),
            .in_n      (rn[g]),
            .in_lo     (rlo[g]),
            .in_c      (rc[g]),
            .out_valid (rv[g+1]),
            .out_n     (rn[g+1]),
            .out_lo    (rlo[g+1]),
            .out_c     (rc[g+1])
        );
    end

    // The ring is one past the last complete ring; the offset counts from
    // the first cell of that ring.
    assign sv[0] = rv[LB];
    assign sz[0] = rn[LB] == '0;
    assign sr[0] = rn[LB] - rc[LB];
    assign sl[0] = rlo[LB] + LB'(1);
    assign ss[0] = '0;

    for (genvar g = 0; g < NSIDE; g++)
    begin : g_side
        hsi_side_cell #(
            .IB (IB),
            .LB (LB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[LB+g]),
            .in_valid  (sv[g]),
            .in_zero   (sz[g]),
            .in_rem    (sr[g]),
            .in_layer  (sl[g]),
            .in_side   (ss[g]),
            .out_valid (sv[g+1]),
            .out_zero  (sz[g+1]),
            .out_rem   (sr[g+1]),
            .out_layer (sl[g+1]),
            .out_side  (ss[g+1])
        );
    end

    always_comb
    begin
        layer_c = coord_t'(sl[NSIDE]);
        step_c  = coord_t'(sr[NSIDE]) + coord_t'(1);
        nside   = next_side(ss[NSIDE]);
        x_next  = scale(layer_c, corner_x(ss[NSIDE]))
                + scale(step_c, coef_t'(corner_x(nside) - corner_x(ss[NSIDE])));
        y_next  = scale(layer_c, corner_y(ss[NSIDE]))
                + scale(step_c, coef_t'(corner_y(nside) - corner_y(ss[NSIDE])));
        if (sz[NSIDE])
        begin
            x_next = '0;
            y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en[NST-1])
        begin
            out_valid_reg <= sv[NSIDE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign coord_ch.valid   = out_valid_reg;
    assign coord_ch.x_coord = x_reg;
    assign coord_ch.y_coord = y_reg;
endmodule
